// ===== src/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared constants and operation codes of the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int unsigned CAPACITY_DEF = 4096;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned LEN_W   = 12;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DEL_BACK = 3'd1,
    OP_DEL_FWD  = 3'd2,
    OP_MOVE_BK  = 3'd3,
    OP_MOVE_FW  = 3'd4,
    OP_READ     = 3'd5
  } op_e;

endpackage

// ===== src/gbts_in_if.sv =====
// ----------------------------------------------------------------------------
// gbts_in_if
// Operation channel: valid/ready handshake with one edit operation per word.
// ----------------------------------------------------------------------------
interface gbts_in_if;
  import gbts_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  index;

  modport source (output valid, output op, output data_byte, output count,
                  output index, input ready);
  modport sink   (input valid, input op, input data_byte, input count,
                  input index, output ready);
endinterface

// ===== src/gbts_out_if.sv =====
// ----------------------------------------------------------------------------
// gbts_out_if
// Result channel: valid/ready handshake with one status word per operation.
// ----------------------------------------------------------------------------
interface gbts_out_if;
  import gbts_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  done_res;
  logic [BYTE_W-1:0] read_byte;
  logic              read_valid;
  logic              full_res;
  logic [LEN_W-1:0]  text_length;
  logic [LEN_W-1:0]  cursor;

  modport source (output valid, output done_res, output read_byte,
                  output read_valid, output full_res, output text_length,
                  output cursor, input ready);
  modport sink   (input valid, input done_res, input read_byte,
                  input read_valid, input full_res, input text_length,
                  input cursor, output ready);
endinterface

// ===== src/gbts_store.sv =====
// ----------------------------------------------------------------------------
// gbts_store
// Byte store of the gap buffer: one write port, one read port, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module gbts_store #(
  parameter int unsigned DEPTH = gbts_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [gbts_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [gbts_pkg::BYTE_W-1:0] rdata_o
);
  import gbts_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/gap_buffer_text_store_unit.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_text_store_unit
// Fixed capacity gap buffer: insert, delete, cursor move and indexed read.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation word (op, data_byte, count, index); out_o
//   returns one status word for each (done_res, read_byte, read_valid,
//   full_res, text_length, cursor). Both use valid/ready.
//   Flow: insert, delete, read and unused ops pass from S_EXEC to S_EMIT.
//   A cursor move also runs S_RD and then S_WR for each byte moved: each
//   moved byte is a read and then a dependent write of the byte store, so
//   the move loop sets the rate.
//   One operation is worked on at a time; a new word is taken once the
//   unit is idle and the previous result has left or leaves in that cycle.
//   Reset leaves an empty text with the cursor at 0. The store contents are
//   not cleared; only cells that hold text are ever read.
//   A stalled receiver keeps the result word held in the output register
//   and holds off new operations until it is taken.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_unit #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gbts_in_if.sink           in_i,
  gbts_out_if.source        out_o
);
  import gbts_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  // common arithmetic width: covers pointers, gap size and count
  localparam int unsigned XW = ((AW + 1) > CNT_W) ? (AW + 1) : CNT_W;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]     gap_start_q, gap_start_d;
  logic [AW-1:0]     gap_end_q, gap_end_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic [CNT_W-1:0]  done_q, done_d;
  logic              full_q, full_d;
  logic              rvalid_q, rvalid_d;
  logic              out_valid_q, out_valid_d;

  // operation word held while it is worked on
  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] data_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  index_q;

  logic [CNT_W-1:0]  res_done_q;
  logic [BYTE_W-1:0] res_byte_q;
  logic              res_rvalid_q;
  logic              res_full_q;
  logic [LEN_W-1:0]  res_len_q;
  logic [LEN_W-1:0]  res_cursor_q;

  logic              in_fire;
  logic              out_fire;

  logic [XW-1:0]     gs_x, ge_x, gap_x, len_x, after_x, idx_x, cnt_x;
  logic [XW-1:0]     limit_x, min_x, raddr_x;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign gs_x    = XW'(gap_start_q);
  assign ge_x    = XW'(gap_end_q);
  assign gap_x   = ge_x - gs_x + XW'(1);
  assign len_x   = CAP_X - gap_x;
  assign after_x = CAP_X - XW'(1) - ge_x;
  assign idx_x   = XW'(index_q);
  assign cnt_x   = XW'(count_q);

  // shared bound unit: count clipped at the text on the side of the op
  assign limit_x = ((op_q == OP_DEL_BACK) || (op_q == OP_MOVE_BK)) ? gs_x : after_x;
  assign min_x   = (cnt_x < limit_x) ? cnt_x : limit_x;

  assign raddr_x = (idx_x < gs_x) ? idx_x : (idx_x + gap_x);

  gbts_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    gap_start_d = gap_start_q;
    gap_end_d   = gap_end_q;
    remain_d    = remain_q;
    done_d      = done_q;
    full_d      = full_q;
    rvalid_d    = rvalid_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = gap_start_q;
    mem_wdata   = data_q;
    mem_re      = 1'b0;
    mem_raddr   = AW'(raddr_x);

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          done_d   = '0;
          full_d   = 1'b0;
          rvalid_d = 1'b0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_EMIT;
        case (op_q)
          OP_INSERT: begin
            if (gap_x <= XW'(1)) begin
              full_d = 1'b1;
            end else begin
              mem_we      = 1'b1;
              gap_start_d = AW'(gs_x + XW'(1));
              done_d      = CNT_W'(1);
            end
          end
          OP_DEL_BACK: begin
            done_d      = CNT_W'(min_x);
            gap_start_d = AW'(gs_x - min_x);
          end
          OP_DEL_FWD: begin
            done_d    = CNT_W'(min_x);
            gap_end_d = AW'(ge_x + min_x);
          end
          OP_MOVE_BK, OP_MOVE_FW: begin
            done_d   = CNT_W'(min_x);
            remain_d = CNT_W'(min_x);
            if (min_x != '0) begin
              state_d = S_RD;
            end
          end
          OP_READ: begin
            if (idx_x < len_x) begin
              mem_re   = 1'b1;
              rvalid_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        mem_re = 1'b1;
        if (op_q == OP_MOVE_BK) begin
          mem_raddr = AW'(gs_x - XW'(1));
        end else begin
          mem_raddr = AW'(ge_x + XW'(1));
        end
        state_d = S_WR;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (op_q == OP_MOVE_BK) begin
          mem_waddr   = gap_end_q;
          gap_start_d = AW'(gs_x - XW'(1));
          gap_end_d   = AW'(ge_x - XW'(1));
        end else begin
          mem_waddr   = gap_start_q;
          gap_start_d = AW'(gs_x + XW'(1));
          gap_end_d   = AW'(ge_x + XW'(1));
        end
        remain_d = remain_q - CNT_W'(1);
        state_d  = (remain_q == CNT_W'(1)) ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gap_start_q <= '0;
      gap_end_q   <= AW'(CAPACITY - 1);
      remain_q    <= '0;
      done_q      <= '0;
      full_q      <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gap_start_q <= gap_start_d;
      gap_end_q   <= gap_end_d;
      remain_q    <= remain_d;
      done_q      <= done_d;
      full_q      <= full_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= in_i.op;
      data_q  <= in_i.data_byte;
      count_q <= in_i.count;
      index_q <= in_i.index;
    end
    if (state_q == S_EMIT) begin
      res_done_q   <= done_q;
      res_byte_q   <= rvalid_q ? mem_rdata : '0;
      res_rvalid_q <= rvalid_q;
      res_full_q   <= full_q;
      res_len_q    <= len_x[LEN_W-1:0];
      res_cursor_q <= gs_x[LEN_W-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.done_res    = res_done_q;
  assign out_o.read_byte   = res_byte_q;
  assign out_o.read_valid  = res_rvalid_q;
  assign out_o.full_res    = res_full_q;
  assign out_o.text_length = res_len_q;
  assign out_o.cursor      = res_cursor_q;

  // the gap always keeps at least one cell
  a_gap_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_end_q >= gap_start_q)
    else $error("gap collapsed");

  // a byte move shifts the gap but keeps its size
  a_move_keeps_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |=> $stable(gap_x))
    else $error("gap size changed during move");

  // the move loop never runs with nothing left to copy
  a_move_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RD) || (state_q == S_WR)) |-> (remain_q != '0))
    else $error("move loop with zero remaining");

  // every accepted word leads to a result once its work ends
  a_emit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("result not presented");

  // no new word while a result is held and not being taken
  a_no_accept_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("accepted word with result stalled");

endmodule
